// File: sv/fnu_pkg.sv
// Shared types and constants for the facet normal unit.
`timescale 1ns / 1ps
package fnu_pkg;
  localparam int COORD_BITS_DEF = 24;
  localparam int EDGE_BITS = 30;
  localparam int CROSS_BITS = 61;
  localparam int MAG_BITS = 30;
  localparam int SUM_BITS = 62;
  localparam int ROOT_BITS = 31;
  localparam int NORM_BITS = 16;
  localparam int QUO_BITS = 15;
  localparam int NORM_ONE = 16384;

  typedef struct packed {
    logic signed [COORD_BITS_DEF-1:0] first_x;
    logic signed [COORD_BITS_DEF-1:0] first_y;
    logic signed [COORD_BITS_DEF-1:0] first_z;
    logic signed [COORD_BITS_DEF-1:0] second_x;
    logic signed [COORD_BITS_DEF-1:0] second_y;
    logic signed [COORD_BITS_DEF-1:0] second_z;
    logic signed [COORD_BITS_DEF-1:0] last_x;
    logic signed [COORD_BITS_DEF-1:0] last_y;
    logic signed [COORD_BITS_DEF-1:0] last_z;
  } in_word_t;

  typedef struct packed {
    logic signed [NORM_BITS-1:0] normal_x;
    logic signed [NORM_BITS-1:0] normal_y;
    logic signed [NORM_BITS-1:0] normal_z;
    logic                        degenerate;
  } out_word_t;

  // Word carried along the cell chain
  typedef struct packed {
    logic                  valid;
    logic [2:0]            neg;
    logic [MAG_BITS-1:0]   ax;
    logic [MAG_BITS-1:0]   ay;
    logic [MAG_BITS-1:0]   az;
    logic [SUM_BITS-1:0]   rem;
    logic [ROOT_BITS-1:0]  root;
  } chain_t;

  // Divider cell word: one quotient bit per cell for three components
  typedef struct packed {
    logic                     valid;
    logic [2:0]               neg;
    logic                     degen;
    logic [ROOT_BITS+1:0]     den;
    logic [3*(ROOT_BITS+2)-1:0] rem;
    logic [3*QUO_BITS-1:0]    quo;
  } dchain_t;
endpackage

// File: sv/facet_normal_unit.sv
// Top level of the facet normal unit: edges, cross product, root and divide chains.
`timescale 1ns / 1ps
// Usage
// in_valid/in_ready take one face word (three vertices) per cycle while in_ready is high.
// out_valid/out_ready deliver one normal word per face, in order.
// Register stages in order: edge/cross, scaling, square-sum, 31 root cells,
// divide set-up, 15 divide cells, output: 54 register stages in all.
// Throughput: one face per cycle when the receiver does not stall, set by the
// fully pipelined chain of root and divider cells, each holding one word.
// Cross terms are split into six 30x30 products, all in one register stage.
// Reset (rst_n low, synchronous) clears all valid bits; payload holds.
// When the receiver stalls, the whole chain holds (shared enable) and
// in_ready falls; a word waiting at the output is kept unchanged.
module facet_normal_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fnu_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fnu_pkg::out_word_t out_data
);
  import fnu_pkg::*;
  localparam int COORD_BITS = COORD_BITS_DEF;
  localparam int ESH = (COORD_BITS > 29) ? COORD_BITS - 29 : 0;
  localparam int RW = ROOT_BITS + 2;

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: edge vectors
  logic s1_v_r;
  logic signed [EDGE_BITS-1:0] u_r [3];
  logic signed [EDGE_BITS-1:0] w_r [3];
  logic signed [COORD_BITS:0] du [3];
  logic signed [COORD_BITS:0] dw [3];
  logic signed [COORD_BITS-1:0] p0 [3];
  logic signed [COORD_BITS-1:0] p1 [3];
  logic signed [COORD_BITS-1:0] pn [3];

  always_comb begin
    p0[0] = in_data.first_x[COORD_BITS-1:0];
    p0[1] = in_data.first_y[COORD_BITS-1:0];
    p0[2] = in_data.first_z[COORD_BITS-1:0];
    p1[0] = in_data.second_x[COORD_BITS-1:0];
    p1[1] = in_data.second_y[COORD_BITS-1:0];
    p1[2] = in_data.second_z[COORD_BITS-1:0];
    pn[0] = in_data.last_x[COORD_BITS-1:0];
    pn[1] = in_data.last_y[COORD_BITS-1:0];
    pn[2] = in_data.last_z[COORD_BITS-1:0];
    for (int i = 0; i < 3; i++) begin
      du[i] = (COORD_BITS+1)'(p1[i]) - (COORD_BITS+1)'(p0[i]);
      dw[i] = (COORD_BITS+1)'(pn[i]) - (COORD_BITS+1)'(p0[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u_r[i] <= EDGE_BITS'(du[i] >>> ESH);
        w_r[i] <= EDGE_BITS'(dw[i] >>> ESH);
      end
    end
  end

  // stage 2: six products
  logic s2_v_r;
  logic signed [CROSS_BITS-2:0] pr_r [6];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pr_r[0] <= u_r[1] * w_r[2];
      pr_r[1] <= u_r[2] * w_r[1];
      pr_r[2] <= u_r[2] * w_r[0];
      pr_r[3] <= u_r[0] * w_r[2];
      pr_r[4] <= u_r[0] * w_r[1];
      pr_r[5] <= u_r[1] * w_r[0];
    end
  end

  // stage 3: cross product magnitudes and signs
  logic s3_v_r;
  logic [CROSS_BITS-1:0] cm_r [3];
  logic [2:0] neg3_r;
  logic signed [CROSS_BITS-1:0] cx [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cx[i] = CROSS_BITS'(pr_r[2*i]) - CROSS_BITS'(pr_r[2*i+1]);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg3_r[i] <= cx[i][CROSS_BITS-1];
        cm_r[i] <= cx[i][CROSS_BITS-1] ? CROSS_BITS'(-cx[i]) : cx[i];
      end
    end
  end

  // stage 4: block scaling to 30 bits
  logic s4_v_r;
  logic [MAG_BITS-1:0] a_r [3];
  logic [2:0] neg4_r;
  logic [CROSS_BITS-1:0] orv;
  logic [5:0] sc;
  always_comb begin
    orv = cm_r[0] | cm_r[1] | cm_r[2];
    sc = '0;
    for (int k = MAG_BITS; k < CROSS_BITS; k++) begin
      if (orv[k]) sc = 6'(k - MAG_BITS + 1);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      neg4_r <= neg3_r;
      for (int i = 0; i < 3; i++) a_r[i] <= MAG_BITS'(cm_r[i] >> sc);
    end
  end

  // stage 5: squares; stage 6: sum
  logic s5_v_r;
  logic [SUM_BITS-3:0] sq_r [3];
  logic [MAG_BITS-1:0] a5_r [3];
  logic [2:0] neg5_r;
  chain_t c6_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
      c6_r.valid <= 1'b0;
    end else if (en) begin
      s5_v_r <= s4_v_r;
      c6_r.valid <= s5_v_r;
      neg5_r <= neg4_r;
      for (int i = 0; i < 3; i++) begin
        a5_r[i] <= a_r[i];
        sq_r[i] <= a_r[i] * a_r[i];
      end
      c6_r.neg <= neg5_r;
      c6_r.ax <= a5_r[0];
      c6_r.ay <= a5_r[1];
      c6_r.az <= a5_r[2];
      c6_r.rem <= SUM_BITS'(sq_r[0]) + SUM_BITS'(sq_r[1]) + SUM_BITS'(sq_r[2]);
      c6_r.root <= '0;
    end
  end

  // square root chain
  chain_t rc [ROOT_BITS+1];
  assign rc[0] = c6_r;
  for (genvar g = 0; g < ROOT_BITS; g++) begin : g_root
    fnu_root_cell #(.STEP(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .d_in(rc[g]), .d_out(rc[g+1])
    );
  end

  // divide set-up: numerator 2*a*16384 + L over 2L; the numerator is split
  // between the remainder window and the quotient field
  dchain_t dc [QUO_BITS+1];
  dchain_t d0_r;
  logic [RW+QUO_BITS-1:0] num [3];
  always_comb begin
    num[0] = ((RW+QUO_BITS)'(rc[ROOT_BITS].ax) << (QUO_BITS))
             + (RW+QUO_BITS)'(rc[ROOT_BITS].root);
    num[1] = ((RW+QUO_BITS)'(rc[ROOT_BITS].ay) << (QUO_BITS))
             + (RW+QUO_BITS)'(rc[ROOT_BITS].root);
    num[2] = ((RW+QUO_BITS)'(rc[ROOT_BITS].az) << (QUO_BITS))
             + (RW+QUO_BITS)'(rc[ROOT_BITS].root);
  end
  // the remainder window holds num >> QUO_BITS; low bits are shifted in
  // by keeping them in the quotient field first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d0_r.valid <= 1'b0;
    end else if (en) begin
      d0_r.valid <= rc[ROOT_BITS].valid;
      d0_r.neg <= rc[ROOT_BITS].neg;
      d0_r.degen <= (rc[ROOT_BITS].root == '0);
      d0_r.den <= {1'b0, rc[ROOT_BITS].root, 1'b0};
      for (int i = 0; i < 3; i++) begin
        d0_r.rem[i*RW +: RW] <= RW'(num[i] >> QUO_BITS);
        d0_r.quo[i*QUO_BITS +: QUO_BITS] <= num[i][QUO_BITS-1:0];
      end
    end
  end
  assign dc[0] = d0_r;
  for (genvar g = 0; g < QUO_BITS; g++) begin : g_div
    fnu_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .d_in(dc[g]), .d_out(dc[g+1])
    );
  end

  // output register
  logic [QUO_BITS-1:0] q [3];
  logic [NORM_BITS-1:0] nv [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q[i] = dc[QUO_BITS].quo[i*QUO_BITS +: QUO_BITS];
      nv[i] = dc[QUO_BITS].neg[i] ? NORM_BITS'(-{1'b0, q[i]}) : NORM_BITS'({1'b0, q[i]});
      if (dc[QUO_BITS].degen) nv[i] = '0;
    end
  end
  out_word_t out_r;
  logic out_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dc[QUO_BITS].valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_r.normal_x <= nv[0];
      out_r.normal_y <= nv[1];
      out_r.normal_z <= nv[2];
      out_r.degenerate <= dc[QUO_BITS].degen;
    end
  end
  assign out_valid = out_v_r;
  assign out_data = out_r;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word lost under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("ready does not follow chain enable");
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |-> out_data.normal_x == 0 &&
    out_data.normal_y == 0 && out_data.normal_z == 0)
    else $error("degenerate face with non-zero normal");
`endif
endmodule

// File: sv/fnu_root_cell.sv
// One step of the bit-serial integer square root, as a chain cell.
`timescale 1ns / 1ps
module fnu_root_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  fnu_pkg::chain_t d_in,
  output fnu_pkg::chain_t d_out
);
  import fnu_pkg::*;
  localparam int SH = 2 * (ROOT_BITS - 1 - STEP);

  chain_t d_r, d_nxt;
  logic [SUM_BITS+1:0] trial;
  logic [SUM_BITS+1:0] rem_w;

  // restoring step: try (4*root+1) << sh
  always_comb begin
    d_nxt = d_in;
    rem_w = {2'b00, d_in.rem};
    trial = (({{(SUM_BITS+2-ROOT_BITS){1'b0}}, d_in.root} << 2) + 2'd1) << SH;
    if (rem_w >= trial) begin
      rem_w = rem_w - trial;
      d_nxt.root = {d_in.root[ROOT_BITS-2:0], 1'b1};
    end else begin
      d_nxt.root = {d_in.root[ROOT_BITS-2:0], 1'b0};
    end
    d_nxt.rem = rem_w[SUM_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end
  assign d_out = d_r;
endmodule

// File: sv/fnu_div_cell.sv
// One quotient bit of the three normal divisions, as a chain cell.
`timescale 1ns / 1ps
module fnu_div_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  fnu_pkg::dchain_t d_in,
  output fnu_pkg::dchain_t d_out
);
  import fnu_pkg::*;
  localparam int RW = ROOT_BITS + 2;

  dchain_t d_r, d_nxt;
  logic [RW:0] sh;

  // restoring step: next numerator bit comes from the top of the quotient field
  always_comb begin
    d_nxt = d_in;
    for (int i = 0; i < 3; i++) begin
      sh = {d_in.rem[i*RW +: RW], d_in.quo[i*QUO_BITS + QUO_BITS - 1]};
      if (sh >= {1'b0, d_in.den}) begin
        sh = sh - {1'b0, d_in.den};
        d_nxt.quo[i*QUO_BITS +: QUO_BITS] = {d_in.quo[i*QUO_BITS +: QUO_BITS-1], 1'b1};
      end else begin
        d_nxt.quo[i*QUO_BITS +: QUO_BITS] = {d_in.quo[i*QUO_BITS +: QUO_BITS-1], 1'b0};
      end
      d_nxt.rem[i*RW +: RW] = sh[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end
  assign d_out = d_r;
endmodule
